### rtl/rgbhsl_pkg.sv
// Shared types, constants and the divider step function for the RGB to HSL converter.
package rgbhsl_pkg;

  // Channel and result widths.
  localparam int ChanW  = 8;
  localparam int HueW   = 15;
  localparam int SatW   = 16;
  localparam int LightW = 9;

  // Hue sector terms are at most six times the channel spread.
  localparam int TermW = 11;

  // Both divisions take a 24-bit dividend and an 8-bit divisor and give 16 quotient bits.
  localparam int QuotW    = 16;
  localparam int DivSteps = QuotW;
  localparam int NumW     = ChanW + QuotW;

  // One input pixel.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pixel_t;

  // One converted pixel.
  typedef struct packed {
    logic [HueW-1:0]   hue;
    logic [SatW-1:0]   saturation;
    logic [LightW-1:0] lightness;
    logic [ChanW-1:0]  alpha_out;
  } hsl_t;

  // Partial remainder and shift register of one restoring divider lane. The shift
  // register starts with the low dividend bits and ends with the quotient.
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [QuotW-1:0] acc;
  } div_lane_t;

  // Everything that travels through the divider pipeline for one pixel.
  typedef struct packed {
    div_lane_t         hue_lane;
    div_lane_t         sat_lane;
    logic [ChanW-1:0]  hue_div;
    logic [ChanW-1:0]  sat_div;
    logic              grey;
    logic [LightW-1:0] lightness;
    logic [ChanW-1:0]  alpha;
  } div_item_t;

  // One restoring division step: bring down the next dividend bit, subtract the
  // divisor when it fits and shift the quotient bit in at the bottom.
  function automatic div_lane_t div_step(div_lane_t x, logic [ChanW-1:0] dv);
    logic [ChanW:0] t;
    logic [ChanW:0] diff;
    div_lane_t      y;
    t    = {x.rem, x.acc[QuotW-1]};
    diff = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      y.rem = diff[ChanW-1:0];
      y.acc = {x.acc[QuotW-2:0], 1'b1};
    end else begin
      y.rem = t[ChanW-1:0];
      y.acc = {x.acc[QuotW-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

### rtl/rgbhsl_divider.sv
// Pipelined restoring divider for hue and saturation, one quotient bit per stage.
module rgbhsl_divider
  import rgbhsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  logic      valid [DivSteps];
  div_item_t item  [DivSteps];
  logic      rdy   [DivSteps];
  logic      src_valid [DivSteps];
  div_item_t src_item  [DivSteps];

  always_comb begin
    src_valid[0] = in_valid;
    src_item[0]  = in_item;
    for (int k = 1; k < DivSteps; k++) begin
      src_valid[k] = valid[k-1];
      src_item[k]  = item[k-1];
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    div_item_t item_next;

    // A stage takes new data when it is empty or its content moves on.
    if (k == DivSteps - 1) begin : g_last
      assign rdy[k] = !valid[k] || out_ready;
    end else begin : g_mid
      assign rdy[k] = !valid[k] || rdy[k+1];
    end

    always_comb begin
      item_next          = src_item[k];
      item_next.hue_lane = div_step(src_item[k].hue_lane, src_item[k].hue_div);
      item_next.sat_lane = div_step(src_item[k].sat_lane, src_item[k].sat_div);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_valid[k]) begin
        item[k] <= item_next;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid[DivSteps-1];
  assign out_item  = item[DivSteps-1];

endmodule

### rtl/rgb_to_hsl_converter.sv
// RGB to HSL converter: three front stages and a 16-stage pipelined divider.
// A pixel passes through stages 1 to 3, then through every divider stage in order.
// While hsl_stall is low, a new pixel may enter every cycle (one pixel per clock).
// Every stage holds when the stage after it is full and stalled, so empty stages
// still fill while the output waits. Reset (rst, synchronous) clears all valid bits;
// the data registers are not reset.
module rgb_to_hsl_converter
  import rgbhsl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  pixel_t pixel,
  output logic   hsl_valid,
  input  logic   hsl_stall,
  output hsl_t   hsl
);

  // Which channel is greatest; red wins ties over green, green over blue.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Stage 1: greatest and least channel.
  logic             s1_valid;
  pixel_t           s1_px;
  logic [ChanW-1:0] s1_mx;
  logic [ChanW-1:0] s1_mn;
  sector_t          s1_sector;

  // Stage 2: spread, sum, saturation divisor and hue sector term.
  logic              s2_valid;
  logic [ChanW-1:0]  s2_d;
  logic [LightW-1:0] s2_sum;
  logic [ChanW-1:0]  s2_den;
  logic [TermW-1:0]  s2_term;
  logic [ChanW-1:0]  s2_alpha;

  // Stage 3: dividends, ready to enter the divider.
  logic      s3_valid;
  div_item_t s3_item;
  div_item_t s3_next;

  logic r1;
  logic r2;
  logic r3;
  logic div_ready;
  logic div_valid;
  div_item_t div_out;

  // Combinational values feeding each stage.
  logic [ChanW-1:0]  mx_c;
  logic [ChanW-1:0]  mn_c;
  logic [ChanW-1:0]  mn_rg;
  sector_t           sector_c;
  logic [ChanW-1:0]  d_c;
  logic [LightW-1:0] sum_c;
  logic [LightW-1:0] sum_rev;
  logic [ChanW-1:0]  den_c;
  logic [TermW-1:0]  term_c;
  logic [TermW-1:0]  d_ext;
  logic [NumW-1:0]   term_ext;
  logic [NumW-1:0]   hue_num;
  logic [NumW-1:0]   sat_num;

  // Backpressure: a stage accepts when it is empty or its content leaves.
  assign r3          = !s3_valid || div_ready;
  assign r2          = !s2_valid || r3;
  assign r1          = !s1_valid || r2;
  assign pixel_stall = !r1;

  // Find the greatest and least channel of the incoming pixel.
  always_comb begin
    if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
      sector_c = SEC_RED;
      mx_c     = pixel.red;
    end else if (pixel.green >= pixel.blue) begin
      sector_c = SEC_GREEN;
      mx_c     = pixel.green;
    end else begin
      sector_c = SEC_BLUE;
      mx_c     = pixel.blue;
    end
    mn_rg = (pixel.red < pixel.green) ? pixel.red : pixel.green;
    mn_c  = (mn_rg < pixel.blue) ? mn_rg : pixel.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (r1) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && pixel_valid) begin
      s1_px     <= pixel;
      s1_mx     <= mx_c;
      s1_mn     <= mn_c;
      s1_sector <= sector_c;
    end
  end

  // The hue numerator is 3840 times a sector term measured in units of the spread:
  // red greatest gives green minus blue, wrapped by six spreads when negative;
  // green greatest gives two spreads plus blue minus red; blue greatest gives four
  // spreads plus red minus green. Every term ends up non-negative and below six
  // spreads, so modular arithmetic in the term width is exact.
  always_comb begin
    d_c     = s1_mx - s1_mn;
    sum_c   = {1'b0, s1_mx} + {1'b0, s1_mn};
    sum_rev = LightW'(2 * 255) - sum_c;
    den_c   = (sum_c <= LightW'(255)) ? sum_c[ChanW-1:0] : sum_rev[ChanW-1:0];
    d_ext   = TermW'(d_c);
    unique case (s1_sector)
      SEC_RED: begin
        if (s1_px.green >= s1_px.blue) begin
          term_c = TermW'(s1_px.green) - TermW'(s1_px.blue);
        end else begin
          term_c = (d_ext << 2) + (d_ext << 1) + TermW'(s1_px.green) - TermW'(s1_px.blue);
        end
      end
      SEC_GREEN: term_c = (d_ext << 1) + TermW'(s1_px.blue) - TermW'(s1_px.red);
      SEC_BLUE:  term_c = (d_ext << 2) + TermW'(s1_px.red) - TermW'(s1_px.green);
      default:   term_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (r2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && s1_valid) begin
      s2_d     <= d_c;
      s2_sum   <= sum_c;
      s2_den   <= den_c;
      s2_term  <= term_c;
      s2_alpha <= s1_px.alpha;
    end
  end

  // Dividends: 3840 times the term (4096 minus 256), and 65535 times the spread.
  // Both quotients stay below 2^16, so the upper byte starts below the divisor.
  always_comb begin
    term_ext = NumW'(s2_term);
    hue_num  = (term_ext << 12) - (term_ext << 8);
    sat_num  = {s2_d, {QuotW{1'b0}}} - NumW'(s2_d);

    s3_next.hue_lane.rem = hue_num[NumW-1:QuotW];
    s3_next.hue_lane.acc = hue_num[QuotW-1:0];
    s3_next.sat_lane.rem = sat_num[NumW-1:QuotW];
    s3_next.sat_lane.acc = sat_num[QuotW-1:0];
    s3_next.hue_div      = s2_d;
    s3_next.sat_div      = s2_den;
    s3_next.grey         = (s2_d == '0);
    s3_next.lightness    = s2_sum;
    s3_next.alpha        = s2_alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (r3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && s2_valid) begin
      s3_item <= s3_next;
    end
  end

  rgbhsl_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (div_ready),
    .in_item   (s3_item),
    .out_valid (div_valid),
    .out_ready (!hsl_stall),
    .out_item  (div_out)
  );

  // The last divider stage is the output register. Grey pixels have a zero hue
  // divisor, so their hue quotient is meaningless; both quotients are set to zero.
  assign hsl_valid = div_valid;
  always_comb begin
    hsl.hue        = div_out.grey ? '0 : div_out.hue_lane.acc[HueW-1:0];
    hsl.saturation = div_out.grey ? '0 : div_out.sat_lane.acc;
    hsl.lightness  = div_out.lightness;
    hsl.alpha_out  = div_out.alpha;
  end

endmodule
